FILE: hw/rtl/dmc_pkg.sv
`default_nettype none

package dmc_pkg;

  // Grid limits; the visited map holds one row of MAX_WIDTH bits per grid row.
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int SEW  = XW + YW;               // stack entry {y, x}
  localparam int SAW  = $clog2(CELLS);         // stack address
  localparam int CNTW = $clog2(CELLS + 1);     // stack fill count

  // Fixed field widths of the ports.
  localparam int COORD_W = 5;
  localparam int CFG_DW  = 6;
  localparam int CFG_AW  = 1;

  // Bounds compares run at this width so that sizes and coordinates both fit.
  localparam int CMPW = ((XW > YW) ? ((XW > CFG_DW) ? XW : CFG_DW)
                                   : ((YW > CFG_DW) ? YW : CFG_DW)) + 1;

  localparam logic [CFG_DW-1:0] CFG_SIZE_RESET = CFG_DW'(32);

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_CARVE = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_DONE  = 2'd2,
    ACT_START = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_e;

endpackage

`default_nettype wire

FILE: hw/rtl/dfs_maze_carver.sv
// Step word: accept, stack read, three visited-row reads, decide and write back, output load;
//   one word in flight, so the next word is taken only once the result is loaded.
// Start word: result valid follows the clearing sweep over the rows.
// Step on an empty stack: straight to the output load. A stalled result holds the sequencer in
//   its output state; a finished result may wait while the next word enters.
// Reset (rst_ni low, asynchronous): stack empty, sizes 32 by 32, no result pending;
//   the visited map is not swept at reset, since only a start makes it readable.
`default_nettype none

module dfs_maze_carver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [1:0]                     random_pick_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     action_o,
  output logic [dmc_pkg::COORD_W-1:0]    cell_x_o,
  output logic [dmc_pkg::COORD_W-1:0]    cell_y_o,
  output logic [dmc_pkg::COORD_W-1:0]    next_x_o,
  output logic [dmc_pkg::COORD_W-1:0]    next_y_o,
  output logic [1:0]                     wall_side_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dmc_pkg::CFG_AW-1:0]     cfg_index_i,
  input  logic [dmc_pkg::CFG_DW-1:0]     cfg_data_i
);

  import dmc_pkg::*;

  // Sequencer: one word at a time. Each memory read of a step has its own state and the
  // writes come in S_DECIDE, so a write lands before the next read of the same row or entry.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,   // sweep visited rows, seed cell (0,0)
    S_TOP,     // read stack top
    S_RD_C,    // latch top cell, read its own row
    S_RD_U,    // latch own row, read row above
    S_RD_D,    // latch row above, read row below
    S_DECIDE,  // pick neighbour, write visited row and stack
    S_OUT      // hand result to the output register
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CFG_DW-1:0] width_q, height_q;

  // Step context
  logic [CNTW-1:0]      cnt_q;
  logic [YW-1:0]        clr_q;
  logic [1:0]           pick_q;
  logic [XW-1:0]        cx_q;
  logic [YW-1:0]        cy_q;
  logic [MAX_WIDTH-1:0] row_c_q, row_u_q;

  // Pending result
  action_e   res_act_q;
  logic [XW-1:0] res_cx_q, res_nx_q;
  logic [YW-1:0] res_cy_q, res_ny_q;
  side_e     res_side_q;

  // Output register
  logic               out_valid_q;
  logic [1:0]         out_act_q, out_side_q;
  logic [COORD_W-1:0] out_cx_q, out_cy_q, out_nx_q, out_ny_q;

  // Visited map: one row of MAX_WIDTH bits per grid row
  logic [MAX_WIDTH-1:0] vis_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] vis_rdata_q;
  logic [YW-1:0]        vis_raddr, vis_waddr;
  logic                 vis_we;
  logic [MAX_WIDTH-1:0] vis_wdata;

  // Path stack: {y, x} per entry
  logic [SEW-1:0] stk_mem [CELLS];
  logic [SEW-1:0] stk_rdata_q;
  logic [SAW-1:0] stk_raddr, stk_waddr;
  logic           stk_we;
  logic [SEW-1:0] stk_wdata;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready; the user must write only while idle, the block does not enforce it.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_RESET;
      height_q <= CFG_SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbour gathering on the latched rows. The row below is still in the
  // read register during S_DECIDE.
  // ---------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0] row_d;
  logic [XW-1:0]        cx_inc, cx_dec;
  logic [YW-1:0]        cy_inc, cy_dec;
  logic [CMPW-1:0]      cx_p1, cy_p1;
  logic [3:0]           cand;
  logic [2:0]           n_cand;
  logic [1:0]           k_sel, seen;
  side_e                sel_side;
  logic [XW-1:0]        nx;
  logic [YW-1:0]        ny;
  logic [MAX_WIDTH-1:0] new_row;
  logic [CNTW-1:0]      cnt_dec;

  assign row_d   = vis_rdata_q;
  assign cx_inc  = cx_q + XW'(1);
  assign cx_dec  = cx_q - XW'(1);
  assign cy_inc  = cy_q + YW'(1);
  assign cy_dec  = cy_q - YW'(1);
  assign cx_p1   = CMPW'(cx_q) + CMPW'(1);
  assign cy_p1   = CMPW'(cy_q) + CMPW'(1);
  assign cnt_dec = cnt_q - CNTW'(1);

  // A size register of zero behaves as one: both compares then fail, as they should.
  always_comb begin
    cand[SIDE_LEFT]   = (cx_q != '0) && !row_c_q[cx_dec];
    cand[SIDE_RIGHT]  = (cx_p1 < CMPW'(width_q)) && (cx_p1 < CMPW'(MAX_WIDTH))
                        && !row_c_q[cx_inc];
    cand[SIDE_TOP]    = (cy_q != '0) && !row_u_q[cx_q];
    cand[SIDE_BOTTOM] = (cy_p1 < CMPW'(height_q)) && (cy_p1 < CMPW'(MAX_HEIGHT))
                        && !row_d[cx_q];
  end

  assign n_cand = 3'($countones(cand));

  // random_pick modulo the candidate count
  always_comb begin
    case (n_cand)
      3'd2:    k_sel = {1'b0, pick_q[0]};
      3'd3:    k_sel = (pick_q == 2'd3) ? 2'd0 : pick_q;
      3'd4:    k_sel = pick_q;
      default: k_sel = 2'd0;
    endcase
  end

  // Walk the candidates in order left, right, up, down; take the k-th one.
  always_comb begin
    seen     = 2'd0;
    sel_side = SIDE_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == k_sel) sel_side = side_e'(2'(i));
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    nx      = cx_q;
    ny      = cy_q;
    new_row = row_c_q;
    case (sel_side)
      SIDE_LEFT:   nx = cx_dec;
      SIDE_RIGHT:  nx = cx_inc;
      SIDE_TOP: begin
        ny      = cy_dec;
        new_row = row_u_q;
      end
      SIDE_BOTTOM: begin
        ny      = cy_inc;
        new_row = row_d;
      end
      default: ;
    endcase
    new_row[nx] = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Memory access control
  // ---------------------------------------------------------------------------
  always_comb begin
    vis_raddr = '0;
    vis_we    = 1'b0;
    vis_waddr = '0;
    vis_wdata = '0;
    stk_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        // clear each row; row 0 comes back with cell (0,0) marked, and (0,0) is pushed
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = (clr_q == '0) ? MAX_WIDTH'(1) : '0;
        stk_we    = (clr_q == '0);
      end
      S_TOP:  stk_raddr = cnt_dec[SAW-1:0];
      S_RD_C: vis_raddr = stk_rdata_q[SEW-1:XW];
      S_RD_U: vis_raddr = (cy_q == '0) ? '0 : cy_dec;
      S_RD_D: vis_raddr = (cy_q == YW'(MAX_HEIGHT - 1)) ? '0 : cy_inc;
      S_DECIDE: begin
        if (n_cand != 3'd0) begin
          vis_we    = 1'b1;
          vis_waddr = ny;
          vis_wdata = new_row;
          stk_we    = 1'b1;
          stk_waddr = cnt_q[SAW-1:0];
          stk_wdata = {ny, nx};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_rdata_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      clr_q       <= '0;
      pick_q      <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      row_c_q     <= '0;
      row_u_q     <= '0;
      res_act_q   <= ACT_DONE;
      res_cx_q    <= '0;
      res_cy_q    <= '0;
      res_nx_q    <= '0;
      res_ny_q    <= '0;
      res_side_q  <= SIDE_LEFT;
      out_valid_q <= 1'b0;
      out_act_q   <= '0;
      out_side_q  <= '0;
      out_cx_q    <= '0;
      out_cy_q    <= '0;
      out_nx_q    <= '0;
      out_ny_q    <= '0;
    end else begin
      // drop the result once taken; in S_OUT a taken result is replaced by the next one
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pick_q     <= random_pick_i;
            res_cx_q   <= '0;
            res_cy_q   <= '0;
            res_nx_q   <= '0;
            res_ny_q   <= '0;
            res_side_q <= SIDE_LEFT;
            if (cmd_e'(command_i) == CMD_START) begin
              clr_q   <= '0;
              state_q <= S_CLEAR;
            end else if (cnt_q == '0) begin
              res_act_q <= ACT_DONE;
              state_q   <= S_OUT;
            end else begin
              state_q <= S_TOP;
            end
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + YW'(1);
          if (clr_q == YW'(MAX_HEIGHT - 1)) begin
            cnt_q     <= CNTW'(1);
            res_act_q <= ACT_START;
            state_q   <= S_OUT;
          end
        end
        S_TOP: state_q <= S_RD_C;
        S_RD_C: begin
          cx_q    <= stk_rdata_q[XW-1:0];
          cy_q    <= stk_rdata_q[SEW-1:XW];
          state_q <= S_RD_U;
        end
        S_RD_U: begin
          row_c_q <= vis_rdata_q;
          state_q <= S_RD_D;
        end
        S_RD_D: begin
          row_u_q <= vis_rdata_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          res_cx_q <= cx_q;
          res_cy_q <= cy_q;
          if (n_cand == 3'd0) begin
            cnt_q     <= cnt_dec;
            res_act_q <= ACT_BACK;
          end else begin
            cnt_q      <= cnt_q + CNTW'(1);
            res_act_q  <= ACT_CARVE;
            res_nx_q   <= nx;
            res_ny_q   <= ny;
            res_side_q <= sel_side;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_act_q   <= res_act_q;
            out_side_q  <= res_side_q;
            out_cx_q    <= COORD_W'(res_cx_q);
            out_cy_q    <= COORD_W'(res_cy_q);
            out_nx_q    <= COORD_W'(res_nx_q);
            out_ny_q    <= COORD_W'(res_ny_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign action_o    = out_act_q;
  assign cell_x_o    = out_cx_q;
  assign cell_y_o    = out_cy_q;
  assign next_x_o    = out_nx_q;
  assign next_y_o    = out_ny_q;
  assign wall_side_o = out_side_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dmc_chk.sv
`default_nettype none

module dmc_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [1:0]                     action_o,
  input  logic [dmc_pkg::COORD_W-1:0]    cell_x_o,
  input  logic [dmc_pkg::COORD_W-1:0]    cell_y_o,
  input  logic [dmc_pkg::COORD_W-1:0]    next_x_o,
  input  logic [dmc_pkg::COORD_W-1:0]    next_y_o,
  input  logic [1:0]                     wall_side_o
);

  import dmc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(cell_x_o)
      && $stable(cell_y_o) && $stable(next_x_o) && $stable(next_y_o) && $stable(wall_side_o))
    else $error("result word changed while stalled");

  // a carved neighbour sits next to the current cell on the reported side
  a_carve_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_CARVE) |->
      ((wall_side_o == SIDE_LEFT)   && (next_x_o + 5'd1 == cell_x_o) && (next_y_o == cell_y_o))
   || ((wall_side_o == SIDE_RIGHT)  && (next_x_o == cell_x_o + 5'd1) && (next_y_o == cell_y_o))
   || ((wall_side_o == SIDE_TOP)    && (next_y_o + 5'd1 == cell_y_o) && (next_x_o == cell_x_o))
   || ((wall_side_o == SIDE_BOTTOM) && (next_y_o == cell_y_o + 5'd1) && (next_x_o == cell_x_o)))
    else $error("carved neighbour not adjacent on reported side");

  // anything but a carve reports no neighbour and no wall
  a_no_carve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != ACT_CARVE) |->
      (next_x_o == '0) && (next_y_o == '0) && (wall_side_o == '0))
    else $error("non-carve result carries neighbour fields");

  // start and done report cell (0,0)
  a_start_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((action_o == ACT_START) || (action_o == ACT_DONE)) |->
      (cell_x_o == '0) && (cell_y_o == '0))
    else $error("start or done result with nonzero cell");

endmodule

bind dfs_maze_carver dmc_chk u_dmc_chk (.*);

`default_nettype wire

FILE: tb/sv/tb_dfs_maze_carver.sv
`default_nettype none

module tb_dfs_maze_carver;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  // Longest legal stretch without any handshake is the forced receiver hold-off
  // (HOLD_CYCLES) plus one start word's clearing sweep; allow several times that.
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  // Cap on step words per maze, so a full 32 by 32 grid does not eat the budget.
  localparam int STEP_CAP = 300;

  typedef struct packed {
    action_e             act;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  nx;
    logic [COORD_W-1:0]  ny;
    side_e               side;
  } carve_result_t;

  // Block ports; every input starts at a known value.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                command_i     = 1'b0;
  logic [1:0]          random_pick_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [1:0]          action_o;
  logic [COORD_W-1:0]  cell_x_o;
  logic [COORD_W-1:0]  cell_y_o;
  logic [COORD_W-1:0]  next_x_o;
  logic [COORD_W-1:0]  next_y_o;
  logic [1:0]          wall_side_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i   = '0;
  logic [CFG_DW-1:0]   cfg_data_i    = '0;

  // Shadow of the carver: visited map, path stack, fill count and size registers.
  bit                  visited_cells [CELLS];
  int                  carve_path [CELLS];
  int                  path_depth = 0;
  logic [CFG_DW-1:0]   cols_reg = CFG_SIZE_RESET;
  logic [CFG_DW-1:0]   rows_reg = CFG_SIZE_RESET;

  // Results still owed by the block, oldest first.
  carve_result_t       owed_results [$];

  // Knobs shared between the word sender and the result receiver.
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  hold_request  = 0;

  int                  fail_count  = 0;
  int                  words_sent  = 0;
  int                  mazes_begun = 0;
  int                  carve_count = 0;
  int                  back_count  = 0;
  int                  done_count  = 0;
  int                  resize_count = 0;

  dfs_maze_carver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .random_pick_i (random_pick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .next_x_o      (next_x_o),
    .next_y_o      (next_y_o),
    .wall_side_o   (wall_side_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Map a raw size register onto the grid actually searched: zero means one,
  // anything past the maximum means the maximum.
  function automatic int fit_size(logic [CFG_DW-1:0] raw, int max_size);
    if (raw == 0) return 1;
    if (int'(raw) > max_size) return max_size;
    return int'(raw);
  endfunction

  // Advance the shadow by one word and return the result it must produce.
  function automatic carve_result_t carve_step(cmd_e cmd, logic [1:0] pick);
    carve_result_t res;
    int            cols, rows, top, cx, cy, n, k;
    int            cand [4];
    side_e         sides [4];
    res = '0;
    if (cmd == CMD_START) begin
      visited_cells = '{default: 1'b0};
      visited_cells[0] = 1'b1;
      carve_path[0] = 0;
      path_depth = 1;
      res.act = ACT_START;
      mazes_begun++;
      return res;
    end
    // Empty stack: report done, touch nothing.
    if (path_depth == 0) begin
      res.act = ACT_DONE;
      done_count++;
      return res;
    end
    cols = fit_size(cols_reg, MAX_WIDTH);
    rows = fit_size(rows_reg, MAX_HEIGHT);
    top  = carve_path[path_depth-1];
    cx   = top % MAX_WIDTH;
    cy   = top / MAX_WIDTH;
    res.cx = COORD_W'(cx);
    res.cy = COORD_W'(cy);
    // Gather unvisited neighbors in the order left, right, up, down. A top cell
    // left outside a shrunken grid gets no right or down neighbor.
    n = 0;
    if (cx > 0 && !visited_cells[top-1]) begin
      cand[n] = top - 1; sides[n] = SIDE_LEFT; n++;
    end
    if (cx + 1 < cols && !visited_cells[top+1]) begin
      cand[n] = top + 1; sides[n] = SIDE_RIGHT; n++;
    end
    if (cy > 0 && !visited_cells[top-MAX_WIDTH]) begin
      cand[n] = top - MAX_WIDTH; sides[n] = SIDE_TOP; n++;
    end
    if (cy + 1 < rows && !visited_cells[top+MAX_WIDTH]) begin
      cand[n] = top + MAX_WIDTH; sides[n] = SIDE_BOTTOM; n++;
    end
    if (n == 0) begin
      // Dead end: pop, and report the cell that was popped.
      path_depth--;
      res.act = ACT_BACK;
      back_count++;
      return res;
    end
    k = int'(pick) % n;
    visited_cells[cand[k]] = 1'b1;
    carve_path[path_depth] = cand[k];
    path_depth++;
    res.act  = ACT_CARVE;
    res.nx   = COORD_W'(cand[k] % MAX_WIDTH);
    res.ny   = COORD_W'(cand[k] / MAX_WIDTH);
    res.side = sides[k];
    carve_count++;
    return res;
  endfunction

  // Offer one word, idling first at the current rate. Valid stays high after the
  // handshake; only an idle cycle or a drain drops it, so it never toggles in one step.
  task automatic send_word(cmd_e cmd, logic [1:0] pick);
    carve_result_t next_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    random_pick_i <= pick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_res     = carve_step(cmd, pick);
    owed_results = {owed_results, next_res};
    words_sent++;
  endtask

  task automatic step_word();
    send_word(CMD_STEP, 2'($urandom_range(3)));
  endtask

  // Hold off the sender until every owed result is back, then let the block settle.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register; valid is left high so back-to-back writes never toggle it.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_WIDTH) cols_reg = value;
    else rows_reg = value;
  endtask

  // Only call with the block drained.
  task automatic set_sizes(logic [CFG_DW-1:0] cols, logic [CFG_DW-1:0] rows);
    write_reg(CFG_WIDTH, cols);
    write_reg(CFG_HEIGHT, rows);
    cfg_valid_i <= 1'b0;
    resize_count++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result receiver: check each accepted word against the oldest expectation,
  // then pick the stall for the next edge. A hold request stalls for a counted stretch.
  int hold_left = 0;
  always @(posedge clk_i) begin
    carve_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $error("result word with nothing outstanding: action %0d", action_o);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("action", int'(want.act), int'(action_o));
        check_field("cell_x", int'(want.cx), int'(cell_x_o));
        check_field("cell_y", int'(want.cy), int'(cell_y_o));
        check_field("next_x", int'(want.nx), int'(next_x_o));
        check_field("next_y", int'(want.ny), int'(next_y_o));
        check_field("wall_side", int'(want.side), int'(wall_side_o));
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count edges on which no channel moves a word.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results owed",
                 quiet_cycles, owed_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Steps out of reset hit an empty stack and must report done.
  task automatic test_empty_stack();
    send_word(CMD_STEP, 2'd0);
    send_word(CMD_STEP, 2'd3);
    wait_all_results();
  endtask

  // Oversized registers clamp to 32 by 32; walk a corridor to the right, shrink the
  // grid under the walker so it backtracks out of bounds, then restart mid-maze.
  task automatic test_corridor_and_shrink();
    set_sizes(6'd63, 6'd63);
    send_word(CMD_START, 2'd0);
    repeat (5) send_word(CMD_STEP, 2'd0);
    wait_all_results();
    set_sizes(6'd2, 6'd1);
    send_word(CMD_STEP, 2'd1);
    send_word(CMD_STEP, 2'd2);
    send_word(CMD_STEP, 2'd3);
    send_word(CMD_STEP, 2'd0);
    // Stack still holds cells here: restart clears the map and the stack.
    send_word(CMD_START, 2'd3);
    send_word(CMD_STEP, 2'd3);
    send_word(CMD_STEP, 2'd2);
    send_word(CMD_STEP, 2'd1);
    send_word(CMD_STEP, 2'd0);
    wait_all_results();
  endtask

  // Zero sizes act as a single cell: one backtrack, then done.
  task automatic test_zero_size_grid();
    set_sizes(6'd0, 6'd0);
    send_word(CMD_START, 2'd1);
    send_word(CMD_STEP, 2'd2);
    send_word(CMD_STEP, 2'd1);
    wait_all_results();
  endtask

  // Let the block fill up behind a long receiver hold, keep offering words, then
  // pause until everything is back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_sizes(6'd8, 6'd8);
    send_word(CMD_START, 2'd0);
    hold_request <= HOLD_CYCLES;
    repeat (40) step_word();
    wait_all_results();
  endtask

  // Full mazes of random size and picks: mostly small grids, now and then the
  // extremes, with occasional restarts and resizes mid-maze as broken sequences.
  task automatic test_random_mazes(int idle_pct, int stall_rate, int word_budget);
    int first_word, steps, dice;
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    first_word    = words_sent;
    while (words_sent - first_word < word_budget) begin
      wait_all_results();
      dice = $urandom_range(99);
      if (dice < 70) set_sizes(6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)));
      else if (dice < 90) set_sizes(6'($urandom_range(1, 16)), 6'($urandom_range(1, 16)));
      else if (dice < 97) set_sizes(6'($urandom_range(63)), 6'($urandom_range(63)));
      else set_sizes(6'd32, 6'd32);
      send_word(CMD_START, 2'($urandom_range(3)));
      steps = 0;
      while (path_depth != 0 && steps < STEP_CAP &&
             words_sent - first_word < word_budget) begin
        dice = $urandom_range(199);
        if (dice < 3) begin
          send_word(CMD_START, 2'($urandom_range(3)));
        end else if (dice < 5) begin
          wait_all_results();
          set_sizes(6'($urandom_range(63)), 6'($urandom_range(63)));
        end else begin
          step_word();
        end
        steps++;
      end
      // Up to two extra steps; once the maze is finished these must keep reporting done.
      repeat ($urandom_range(2)) step_word();
    end
    wait_all_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_corridor_and_shrink();
    test_zero_size_grid();
    test_backpressure();
    test_random_mazes(0, 0, 420);
    test_random_mazes(58, 0, 420);
    test_random_mazes(0, 58, 420);
    test_random_mazes(31, 31, 420);

    wait_all_results();
    repeat (16) @(posedge clk_i);

    $display("Covered %0d words over %0d mazes and %0d size settings",
             words_sent, mazes_begun, resize_count);
    $display("Results seen: %0d carves, %0d backtracks, %0d done on empty stack",
             carve_count, back_count, done_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/dmc_pkg.sv
hw/rtl/dfs_maze_carver.sv
hw/rtl/dmc_chk.sv
tb/sv/tb_dfs_maze_carver.sv
